// ----- rtl/ppa_pkg.sv -----
// Package for the polygon perimeter/area block: sequencer states, result widths
// and the status type shared by the root unit and the top level.
// No dependencies.
package ppa_pkg;

   localparam int PERIM_W    = 48;   // perimeter result, integer, no fraction bits
   localparam int AREA_W     = 62;   // area result, integer, no fraction bits
   localparam int DAREA_W    = 64;   // signed doubled-area accumulator
   localparam int RSP_DATA_W = 112;  // perimeter + area, padded to bytes

   localparam logic STATUS_CLOSED  = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_DX,
      S_MUL_DY,
      S_MUL_UW,
      S_MUL_VW,
      S_CROSS,
      S_ROOT,
      S_ACC,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

endpackage

// ----- rtl/ppa_mul.sv -----
// Shared signed multiplier with a registered product.
// Used for the squared edge deltas and the fan cross terms; no package use.
module ppa_mul #(
   parameter int Width = 21
) (
   input  logic                      clock,
   input  logic signed [Width-1:0]   op_a,
   input  logic signed [Width-1:0]   op_b,
   output logic signed [2*Width-1:0] prod
);

   logic signed [2*Width-1:0] prod_ff;
   logic signed [2*Width-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/ppa_isqrt.sv -----
// Iterative integer square root, one root bit per cycle (floor result).
// Depends on ppa_pkg for the status struct.
module ppa_isqrt #(
   parameter int RootWidth = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2*RootWidth-1:0]       radicand,
   output logic [RootWidth-1:0]         root,
   output ppa_pkg::root_status_type     status
);
   import ppa_pkg::*;

   localparam int CntW = $clog2(RootWidth + 1);

   logic [2*RootWidth-1:0] rad_ff,  rad_in;
   logic [RootWidth-1:0]   rem_ff,  rem_in;
   logic [RootWidth-1:0]   root_ff, root_in;
   logic [CntW-1:0]        cnt_ff,  cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [RootWidth+1:0]   rem_sh;
   logic [RootWidth+1:0]   trial;
   logic [RootWidth+1:0]   diff;
   logic                   take;

   // bring down the next two radicand bits and try the next root bit
   assign rem_sh = {rem_ff, rad_ff[2*RootWidth-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign take   = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CntW'(RootWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*RootWidth-3:0], 2'b00};
         rem_in  = take ? diff[RootWidth-1:0] : rem_sh[RootWidth-1:0];
         root_in = {root_ff[RootWidth-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- rtl/polygon_perimeter_area.sv -----
// Polygon perimeter and shoelace area: sequencer, accumulators, output register.
// Depends on ppa_pkg, ppa_mul (shared multiplier) and ppa_isqrt (root unit).
//
//  channel | dir | tdata (low bit up)                  | tuser
//  req     | in  | x_coord, y_coord, zero pad          | first_vertex
//  rsp     | out | perimeter[47:0], area[61:0], pad   | status
//
// A vertex that adds an edge makes four passes through the shared multiplier, then
// waits for the root unit resolving one bit a cycle; a vertex that closes the polygon
// also passes through the emit step for its result. Start vertices and ignored vertices
// are taken in the idle state alone; an invalid return goes straight to the emit step.
// req_tready is high only while idle; a result waits in the output register
// and the block stalls in its emit step only if that register is still full.
// Synchronous reset returns the block to idle with no polygon open.
module polygon_perimeter_area #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // x_coord, y_coord, zero pad
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // first_vertex
   input  logic [0:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // perimeter, area, zero pad
   output logic [ppa_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // status
   output logic [0:0]                              rsp_tuser
);
   import ppa_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int OpW    = CW + 1;
   localparam int ProdW  = 2 * OpW;
   localparam int SqW    = 2 * CW + 1;
   localparam int RootW  = CW + 1;
   localparam int RadW   = 2 * RootW;
   localparam int CrossW = ProdW + 1;
   localparam int SumW   = ((CrossW > DAREA_W) ? CrossW : DAREA_W) + 1;

   state_type state_ff, state_in;

   logic [CW-1:0]      start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [CW-1:0]      prev_x_ff,  prev_x_in,  prev_y_ff,  prev_y_in;
   logic [CW-1:0]      cur_x_ff,   cur_x_in,   cur_y_ff,   cur_y_in;
   logic [1:0]         seen_ff,    seen_in;
   logic               active_ff,  active_in;
   logic               closing_ff, closing_in;
   logic               invalid_ff, invalid_in;
   logic [PERIM_W-1:0] perim_ff,   perim_in;
   logic [DAREA_W-1:0] darea_ff,   darea_in;
   logic [SqW-1:0]     sq_ff,      sq_in;
   logic [RadW-1:0]    rad_ff,     rad_in;
   logic [CrossW-1:0]  cross_ff,   cross_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PERIM_W-1:0]    rsp_perim_ff, rsp_perim_in;
   logic [AREA_W-1:0]     rsp_area_ff,  rsp_area_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [CW-1:0]      req_x, req_y;
   logic               req_first;
   logic               req_fire;
   logic               req_is_start;

   logic signed [OpW-1:0]   mul_a, mul_b;
   logic signed [ProdW-1:0] prod;
   logic [OpW-1:0]          dx, dy, ux, uy, wx, wy;
   logic [CrossW-1:0]       prod_ext;

   logic                  root_start;
   logic [RootW-1:0]      root;
   root_status_type       root_stat;

   logic [PERIM_W:0]      perim_sum;
   logic [SumW-1:0]       darea_sum;
   logic [SumW-DAREA_W:0] darea_top;
   logic [DAREA_W-1:0]    darea_abs;
   logic [DAREA_W-2:0]    darea_half;
   logic                  out_free;

   assign req_x     = req_tdata[CW-1:0];
   assign req_y     = req_tdata[2*CW-1:CW];
   assign req_first = req_tuser[0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign req_is_start = (req_x == start_x_ff) && (req_y == start_y_ff);

   // edge deltas and fan vectors, one bit wider than the coordinates
   assign dx = {cur_x_ff[CW-1], cur_x_ff} - {prev_x_ff[CW-1], prev_x_ff};
   assign dy = {cur_y_ff[CW-1], cur_y_ff} - {prev_y_ff[CW-1], prev_y_ff};
   assign ux = {prev_x_ff[CW-1], prev_x_ff} - {start_x_ff[CW-1], start_x_ff};
   assign uy = {prev_y_ff[CW-1], prev_y_ff} - {start_y_ff[CW-1], start_y_ff};
   assign wx = {cur_x_ff[CW-1], cur_x_ff} - {start_x_ff[CW-1], start_x_ff};
   assign wy = {cur_y_ff[CW-1], cur_y_ff} - {start_y_ff[CW-1], start_y_ff};

   assign prod_ext = {prod[ProdW-1], prod};

   assign perim_sum = {1'b0, perim_ff} + (PERIM_W+1)'(root);
   assign darea_sum = {{(SumW-DAREA_W){darea_ff[DAREA_W-1]}}, darea_ff}
                    + {{(SumW-CrossW){cross_ff[CrossW-1]}}, cross_ff};
   assign darea_top = darea_sum[SumW-1:DAREA_W-1];
   assign darea_abs = darea_ff[DAREA_W-1] ? (DAREA_W'(0) - darea_ff) : darea_ff;
   assign darea_half = darea_abs[DAREA_W-1:1];

   assign out_free = !rsp_valid_ff || rsp_tready;

   ppa_mul #(
      .Width (OpW)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   ppa_isqrt #(
      .RootWidth (RootW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (rad_ff),
      .root     (root),
      .status   (root_stat)
   );

   always_comb begin
      state_in      = state_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      seen_in       = seen_ff;
      active_in     = active_ff;
      closing_in    = closing_ff;
      invalid_in    = invalid_ff;
      perim_in      = perim_ff;
      darea_in      = darea_ff;
      sq_in         = sq_ff;
      rad_in        = rad_ff;
      cross_in      = cross_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_perim_in  = rsp_perim_ff;
      rsp_area_in   = rsp_area_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      root_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_first) begin
                  start_x_in = req_x;
                  start_y_in = req_y;
                  prev_x_in  = req_x;
                  prev_y_in  = req_y;
                  seen_in    = 2'd1;
                  active_in  = 1'b1;
                  perim_in   = '0;
                  darea_in   = '0;
               end else if (active_ff) begin
                  cur_x_in   = req_x;
                  cur_y_in   = req_y;
                  closing_in = req_is_start;
                  // start back too early: report invalid without any arithmetic
                  if (req_is_start && seen_ff != 2'd3) begin
                     invalid_in = 1'b1;
                     state_in   = S_EMIT;
                  end else begin
                     invalid_in = 1'b0;
                     state_in   = S_MUL_DX;
                  end
               end
            end
         end
         S_MUL_DX: begin
            mul_a    = dx;
            mul_b    = dx;
            state_in = S_MUL_DY;
         end
         S_MUL_DY: begin
            mul_a    = dy;
            mul_b    = dy;
            sq_in    = prod[SqW-1:0];
            state_in = S_MUL_UW;
         end
         S_MUL_UW: begin
            mul_a    = ux;
            mul_b    = wy;
            rad_in   = {1'b0, sq_ff} + {1'b0, prod[SqW-1:0]};
            state_in = S_MUL_VW;
         end
         S_MUL_VW: begin
            mul_a      = uy;
            mul_b      = wx;
            cross_in   = prod_ext;
            root_start = 1'b1;
            state_in   = S_CROSS;
         end
         S_CROSS: begin
            cross_in = cross_ff - prod_ext;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_stat.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            perim_in = perim_sum[PERIM_W] ? {PERIM_W{1'b1}} : perim_sum[PERIM_W-1:0];
            if (closing_ff) begin
               state_in = S_EMIT;
            end else begin
               // clamp the doubled area to the signed 64-bit range
               if (darea_top == '0 || darea_top == '1) begin
                  darea_in = darea_sum[DAREA_W-1:0];
               end else if (darea_sum[SumW-1]) begin
                  darea_in = {1'b1, {(DAREA_W-1){1'b0}}};
               end else begin
                  darea_in = {1'b0, {(DAREA_W-1){1'b1}}};
               end
               prev_x_in = cur_x_ff;
               prev_y_in = cur_y_ff;
               seen_in   = (seen_ff == 2'd3) ? 2'd3
                         : ((seen_ff == 2'd0) ? 2'd2 : seen_ff + 2'd1);
               state_in  = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (invalid_ff) begin
                  rsp_perim_in  = '0;
                  rsp_area_in   = '0;
                  rsp_status_in = STATUS_INVALID;
               end else begin
                  rsp_perim_in  = perim_ff;
                  rsp_area_in   = darea_half[DAREA_W-2] ? {AREA_W{1'b1}}
                                                        : darea_half[AREA_W-1:0];
                  rsp_status_in = STATUS_CLOSED;
               end
               active_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_x_ff    <= start_x_in;
      start_y_ff    <= start_y_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      closing_ff    <= closing_in;
      invalid_ff    <= invalid_in;
      perim_ff      <= perim_in;
      darea_ff      <= darea_in;
      sq_ff         <= sq_in;
      rad_ff        <= rad_in;
      cross_ff      <= cross_in;
      rsp_perim_ff  <= rsp_perim_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(RSP_DATA_W-PERIM_W-AREA_W){1'b0}}, rsp_area_ff, rsp_perim_ff};
   assign rsp_tuser[0] = rsp_status_ff;

   a_root_start_idle: assert property (@(posedge clock) disable iff (reset)
      root_start |-> !root_stat.busy)
      else $error("root unit restarted while busy");

   a_acc_after_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> !root_stat.busy)
      else $error("accumulating before the root settled");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_EMIT))
      else $error("result emitted over an untaken word");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == STATUS_INVALID) |-> (rsp_tdata == '0))
      else $error("invalid status with nonzero payload");

endmodule

// ----- verif/polygon_perimeter_area_checker.sv -----
// Checker for polygon_perimeter_area: watches both stream channels, predicts each result
// from the accepted vertices and compares it field by field with what the block returns.
// Depends on ppa_pkg for the result widths and status codes.
module polygon_perimeter_area_checker #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   // x_coord, y_coord, zero pad
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // first_vertex
   input  logic [0:0]                              req_tuser,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // perimeter, area, zero pad
   input  logic [ppa_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // status
   input  logic [0:0]                              rsp_tuser,
   output int                                      fail_count,
   output int                                      owed_count,
   output int                                      closed_count,
   output int                                      invalid_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ppa_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam logic [PERIM_W-1:0] PERIM_LIMIT = {PERIM_W{1'b1}};
   localparam logic [AREA_W-1:0]  AREA_LIMIT  = {AREA_W{1'b1}};

   typedef struct {
      logic [PERIM_W-1:0] perimeter;
      logic [AREA_W-1:0]  area;
      logic               status;
   } polygon_result_type;

   polygon_result_type owed_results[$];

   logic signed [CW-1:0]      anchor_x, anchor_y, last_x, last_y;
   int unsigned               corner_count;
   logic                      open_polygon;
   logic [PERIM_W-1:0]        perim_total;
   logic signed [DAREA_W-1:0] twice_area;
   int                        mismatches, closed_seen, invalid_seen;

   // floor(sqrt(dx^2 + dy^2)) between two vertices
   function automatic logic [63:0] edge_root(input logic signed [63:0] ax, ay, bx, by);
      logic signed [63:0] ddx, ddy;
      logic [127:0] dx, dy, sum, cand;
      logic [63:0] root;
      int b;
      ddx = bx - ax;
      ddy = by - ay;
      dx = ddx[63] ? 128'(-ddx) : 128'(ddx);
      dy = ddy[63] ? 128'(-ddy) : 128'(ddy);
      sum = dx * dx + dy * dy;
      root = '0;
      for (b = 35; b >= 0; b--) begin
         cand = 128'(root | (64'd1 << b));
         if (cand * cand <= sum) root = cand[63:0];
      end
      return root;
   endfunction

   task automatic fold_vertex(input logic signed [CW-1:0] vx, vy, input logic first);
      logic signed [63:0] ux, uy, wx, wy;
      logic signed [127:0] fan_term, acc;
      logic [PERIM_W:0] perim_next;
      logic [63:0] mag;
      logic hits_anchor;
      polygon_result_type res;
      if (first) begin
         anchor_x = vx; anchor_y = vy;
         last_x = vx;   last_y = vy;
         corner_count = 1;
         open_polygon = 1'b1;
         perim_total = '0;
         twice_area = '0;
         return;
      end
      if (!open_polygon) return;
      hits_anchor = (vx == anchor_x) && (vy == anchor_y);
      if (hits_anchor && corner_count < 3) begin
         open_polygon = 1'b0;
         res.perimeter = '0;
         res.area = '0;
         res.status = STATUS_INVALID;
         owed_results.push_back(res);
         return;
      end
      perim_next = {1'b0, perim_total}
                 + (PERIM_W+1)'(edge_root(last_x, last_y, vx, vy));
      perim_total = perim_next[PERIM_W] ? PERIM_LIMIT : perim_next[PERIM_W-1:0];
      if (hits_anchor) begin
         open_polygon = 1'b0;
         mag = twice_area[63] ? (~twice_area + 64'd1) : twice_area;
         mag = mag >> 1;
         res.perimeter = perim_total;
         res.area = (mag > 64'(AREA_LIMIT)) ? AREA_LIMIT : mag[AREA_W-1:0];
         res.status = STATUS_CLOSED;
         owed_results.push_back(res);
         return;
      end
      ux = last_x - anchor_x;
      uy = last_y - anchor_y;
      wx = vx - anchor_x;
      wy = vy - anchor_y;
      fan_term = ux * wy - uy * wx;
      acc = twice_area + fan_term;
      // clamp to the signed 64-bit range instead of wrapping
      if (&acc[127:63] || ~|acc[127:63]) twice_area = acc[63:0];
      else if (acc[127]) twice_area = {1'b1, 63'b0};
      else twice_area = {1'b0, {63{1'b1}}};
      last_x = vx;
      last_y = vy;
      corner_count = (corner_count >= 3) ? 3 : ((corner_count == 0) ? 2 : corner_count + 1);
   endtask

   task automatic check_result();
      polygon_result_type exp_res;
      logic [PERIM_W-1:0] got_perim;
      logic [AREA_W-1:0] got_area;
      got_perim = rsp_tdata[PERIM_W-1:0];
      got_area = rsp_tdata[PERIM_W+AREA_W-1:PERIM_W];
      if (owed_results.size() == 0) begin
         $error("unexpected result word: perimeter %0d area %0d status %0d",
                got_perim, got_area, rsp_tuser[0]);
         mismatches++;
         return;
      end
      exp_res = owed_results.pop_front();
      if (exp_res.status == STATUS_CLOSED) closed_seen++;
      else invalid_seen++;
      if (got_perim !== exp_res.perimeter) begin
         $error("perimeter: expected %0d, got %0d", exp_res.perimeter, got_perim);
         mismatches++;
      end
      if (got_area !== exp_res.area) begin
         $error("area: expected %0d, got %0d", exp_res.area, got_area);
         mismatches++;
      end
      if (rsp_tuser[0] !== exp_res.status) begin
         $error("status: expected %0d, got %0d", exp_res.status, rsp_tuser[0]);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      closed_seen = 0;
      invalid_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         anchor_x = '0; anchor_y = '0; last_x = '0; last_y = '0;
         corner_count = 0;
         open_polygon = 1'b0;
         perim_total = '0;
         twice_area = '0;
         owed_results.delete();
      end else begin
         // a result leaving at this edge always belongs to an earlier vertex
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready)
            fold_vertex(req_tdata[CW-1:0], req_tdata[2*CW-1:CW], req_tuser[0]);
      end
      fail_count    <= mismatches;
      owed_count    <= owed_results.size();
      closed_count  <= closed_seen;
      invalid_count <= invalid_seen;
   end

endmodule

// ----- verif/polygon_perimeter_area_tb.sv -----
// Top of the polygon_perimeter_area testbench: clock, reset, vertex stimulus and verdict.
// Depends on ppa_pkg, the block itself and polygon_perimeter_area_checker.
module polygon_perimeter_area_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppa_pkg::*;

   localparam int CW = 20;
   localparam int REQ_W = ((2*CW+7)/8)*8;
   localparam int VERTEX_TARGET = 1800;
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [REQ_W-1:0]             req_tdata;   // x_coord, y_coord, zero pad
   logic [0:0]                   req_tuser;   // first_vertex
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [RSP_DATA_W-1:0]        rsp_tdata;   // perimeter, area, zero pad
   logic [0:0]                   rsp_tuser;   // status

   int fail_count, owed_count, closed_count, invalid_count;
   int vertices_sent;
   bit calm;     // no idling on either side
   bit steady;   // current polygon goes out without sender gaps

   polygon_perimeter_area #(.COORD_WIDTH(CW)) u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   polygon_perimeter_area_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .owed_count, .closed_count, .invalid_count
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random stall bursts, none once the run turns calm
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still owed", owed_count);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_vertex(input logic signed [CW-1:0] x, y, input logic first);
      if (!calm && !steady && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tdata  <= REQ_W'({y, x});
      req_tuser  <= first;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      vertices_sent++;
   endtask

   function automatic logic signed [CW-1:0] pick_coord(input int spread);
      case (spread)
         0: pick_coord = CW'($urandom);
         1: pick_coord = CW'($urandom_range(0, 8191) - 4096);
         default: begin
            case ($urandom_range(0, 3))
               0: pick_coord = COORD_MIN;
               1: pick_coord = COORD_MAX;
               2: pick_coord = '0;
               default: pick_coord = CW'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic random_polygon();
      int kind, spread, sides, k;
      logic signed [CW-1:0] x0, y0, x, y;
      kind = $urandom_range(0, 99);
      spread = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0);
      steady = ($urandom_range(0, 3) == 0);
      x0 = pick_coord(spread);
      y0 = pick_coord(spread);
      if (kind >= 95) begin
         // noise: loose vertices, start flag at random
         repeat ($urandom_range(1, 4))
            send_vertex(pick_coord(spread), pick_coord(spread), 1'($urandom));
         return;
      end
      send_vertex(x0, y0, 1'b1);
      x = x0;
      y = y0;
      if (kind < 80) sides = $urandom_range(2, 8);
      else if (kind < 88) sides = $urandom_range(0, 1);
      else sides = $urandom_range(0, 3);
      for (k = 0; k < sides; k++) begin
         // occasionally repeat the previous vertex: a zero-length edge
         if (k == 0 || $urandom_range(0, 7) != 0) begin
            x = pick_coord(spread);
            y = pick_coord(spread);
         end
         send_vertex(x, y, 1'b0);
      end
      // abandoned polygons are dropped by the next start vertex
      if (kind < 88) send_vertex(x0, y0, 1'b0);
   endtask

   initial begin
      int waited;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      vertices_sent = 0;
      calm = 1'b0;
      steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // vertex while idle: ignored
      send_vertex(CW'(5), CW'(5), 1'b0);
      // extreme triangle, closed
      send_vertex(COORD_MIN, COORD_MIN, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      // start returns as second vertex, then as third
      send_vertex(CW'(0), CW'(0), 1'b1);
      send_vertex(CW'(0), CW'(0), 1'b0);
      send_vertex(CW'(100), CW'(200), 1'b1);
      send_vertex(CW'(300), CW'(400), 1'b0);
      send_vertex(CW'(100), CW'(200), 1'b0);
      // restart while active, then a square with a repeated corner
      send_vertex(CW'(1), CW'(1), 1'b1);
      send_vertex(CW'(10), CW'(10), 1'b0);
      send_vertex(CW'(0), CW'(0), 1'b1);
      send_vertex(CW'(256), CW'(0), 1'b0);
      send_vertex(CW'(256), CW'(256), 1'b0);
      send_vertex(CW'(256), CW'(256), 1'b0);
      send_vertex(CW'(0), CW'(256), 1'b0);
      send_vertex(CW'(0), CW'(0), 1'b0);
      // clockwise triangle: negative doubled area
      send_vertex(CW'(-1), CW'(-1), 1'b1);
      send_vertex(CW'(-1), CW'(255), 1'b0);
      send_vertex(CW'(255), CW'(255), 1'b0);
      send_vertex(CW'(-1), CW'(-1), 1'b0);
      // vertex after close: ignored
      send_vertex(CW'(7), CW'(7), 1'b0);

      while (vertices_sent < VERTEX_TARGET) begin
         if (vertices_sent > VERTEX_TARGET - 200) calm = 1'b1;
         random_polygon();
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (owed_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      // let a vertex still in flight finish and settle the counters
      repeat (60) @(posedge clock);

      if (owed_count != 0) $error("%0d expected results never arrived", owed_count);
      $display("%0d vertices driven; %0d closed polygons and %0d invalid returns checked",
               vertices_sent, closed_count, invalid_count);
      if (fail_count == 0 && owed_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ppa_pkg.sv
rtl/ppa_mul.sv
rtl/ppa_isqrt.sv
rtl/polygon_perimeter_area.sv
verif/polygon_perimeter_area_checker.sv
verif/polygon_perimeter_area_tb.sv
